>>> rtl/hre_pkg.sv
// Shared widths, register indexes and defaults for the homography
// reprojection error block. No dependencies.
`default_nettype none
package hre_pkg;
	localparam int COORD_W   = 24;  // Q15.8 point coordinate
	localparam int COEF_W    = 32;  // Q11.20 matrix coefficient
	localparam int CFG_W     = 64;  // widest register
	localparam int WMIN_W    = 16;
	localparam int ERR_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = COEF_W + COORD_W;   // one coefficient times one coordinate
	localparam int SUM_W     = PROD_W + 2;         // three-term affine sum
	localparam int QUOT_W    = COORD_W + 1;        // quotient bits before saturation
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * DIFF_W;

	localparam int DEF_COORD_FRAC_BITS = 8;
	localparam int DEF_COEF_FRAC_BITS  = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_XROW_AB       = 3'd0,
		REG_XROW_C_YROW_A = 3'd1,
		REG_YROW_BC       = 3'd2,
		REG_WROW_AB       = 3'd3,
		REG_WROW_C        = 3'd4,
		REG_W_MIN         = 3'd5
	} cfg_reg_t;
endpackage
`default_nettype wire

>>> rtl/homography_reprojection_error.sv
// Homography reprojection error: projects a source point through a 3x3
// homography and returns the projection and the squared distance to a
// destination point. Depends on hre_pkg.
//
// Usage:
//   Input channel in_valid/in_stall carries one correspondence (src_x, src_y,
//   dst_x, dst_y); output channel out_valid/out_stall carries proj_x, proj_y,
//   err_sq and degenerate. A request moves on an edge with valid high and
//   stall low.
//   One request enters per cycle while in_stall is low. The stages are:
//   coefficient products, affine sums, magnitudes and degeneracy check,
//   quotient overflow check, 25 restoring-divider stages (one quotient bit
//   each, X and Y side by side), rounding and saturation, squaring, and the
//   final sum into the output register.
//   When out_stall holds a result, the stages behind it still fill their
//   empty slots; in_stall rises only once every stage holds a request.
//   Reset (arst_n low) empties the pipeline and loads the identity matrix
//   with w_min = 1. The user must write registers (cfg_wr_en/cfg_index/cfg_wdata)
//   only while the block is idle; the block does not enforce it. Indexes above 5 are ignored.
`default_nettype none
module homography_reprojection_error
	import hre_pkg::*;
#(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
	parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire        [CFG_IDX_W-1:0] cfg_index,
	input  wire        [CFG_W-1:0]     cfg_wdata,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire signed [COORD_W-1:0]   src_x,
	input  wire signed [COORD_W-1:0]   src_y,
	input  wire signed [COORD_W-1:0]   dst_x,
	input  wire signed [COORD_W-1:0]   dst_y,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [COORD_W-1:0]  proj_x,
	output logic signed [COORD_W-1:0]  proj_y,
	output logic        [ERR_W-1:0]    err_sq,
	output logic                       degenerate
);
	localparam int NW     = SUM_W + COORD_FRAC_BITS;  // scaled numerator
	localparam int CMP_W  = SUM_W + QUOT_W;           // divisor shifted by a quotient bit
	localparam int DS     = 5;                        // first divider stage
	localparam int S_RND  = DS + QUOT_W;
	localparam int S_SQ   = S_RND + 1;
	localparam int NS     = S_SQ + 1;
	localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(1) << COEF_FRAC_BITS;
	localparam logic [QUOT_W:0] LIM_POS = (QUOT_W+1)'((1 << (COORD_W-1)) - 1);
	localparam logic [QUOT_W:0] LIM_NEG = (QUOT_W+1)'(1 << (COORD_W-1));
	localparam logic [ERR_W:0] ERR_MAX = {1'b0, {ERR_W{1'b1}}};

	// configuration registers
	logic [CFG_W-1:0]  xrow_ab_q, xrow_c_yrow_a_q, yrow_bc_q, wrow_ab_q;
	logic [COEF_W-1:0] wrow_c_q;
	logic [WMIN_W-1:0] w_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xrow_ab_q       <= COEF_ONE;
			xrow_c_yrow_a_q <= '0;
			yrow_bc_q       <= COEF_ONE;
			wrow_ab_q       <= '0;
			wrow_c_q        <= COEF_ONE[COEF_W-1:0];
			w_min_q         <= WMIN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_XROW_AB:       xrow_ab_q       <= cfg_wdata;
				REG_XROW_C_YROW_A: xrow_c_yrow_a_q <= cfg_wdata;
				REG_YROW_BC:       yrow_bc_q       <= cfg_wdata;
				REG_WROW_AB:       wrow_ab_q       <= cfg_wdata;
				REG_WROW_C:        wrow_c_q        <= cfg_wdata[COEF_W-1:0];
				REG_W_MIN:         w_min_q         <= cfg_wdata[WMIN_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [COEF_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	assign h00 = xrow_ab_q[COEF_W-1:0];
	assign h01 = xrow_ab_q[CFG_W-1:COEF_W];
	assign h02 = xrow_c_yrow_a_q[COEF_W-1:0];
	assign h10 = xrow_c_yrow_a_q[CFG_W-1:COEF_W];
	assign h11 = yrow_bc_q[COEF_W-1:0];
	assign h12 = yrow_bc_q[CFG_W-1:COEF_W];
	assign h20 = wrow_ab_q[COEF_W-1:0];
	assign h21 = wrow_ab_q[CFG_W-1:COEF_W];
	assign h22 = wrow_c_q;

	// valid bits and per-stage advance; a stage loads when it is empty or
	// the stage ahead of it loads
	logic [NS:0]   vld_s;
	logic [NS+1:1] adv;
	assign vld_s[0]    = in_valid;
	assign adv[NS+1]   = !out_stall;
	for (genvar k = 1; k <= NS; k++) begin : g_adv
		assign adv[k] = !vld_s[k] || adv[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (adv[k])
				vld_s[k] <= vld_s[k-1];
		end
	end
	assign in_stall  = !adv[1];
	assign out_valid = vld_s[NS];

	// stage 1: products
	logic signed [PROD_W-1:0]  p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [COORD_W-1:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p00_s1 <= h00 * src_x;
			p01_s1 <= h01 * src_y;
			p10_s1 <= h10 * src_x;
			p11_s1 <= h11 * src_y;
			p20_s1 <= h20 * src_x;
			p21_s1 <= h21 * src_y;
			dx_s1  <= dst_x;
			dy_s1  <= dst_y;
		end
	end

	// stage 2: affine sums, constant column scaled to the coordinate unit
	logic signed [SUM_W-1:0]   sx_s2, sy_s2, sw_s2;
	logic signed [COORD_W-1:0] dx_s2, dy_s2;
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sx_s2 <= SUM_W'(p00_s1) + SUM_W'(p01_s1) + (SUM_W'(h02) <<< COORD_FRAC_BITS);
			sy_s2 <= SUM_W'(p10_s1) + SUM_W'(p11_s1) + (SUM_W'(h12) <<< COORD_FRAC_BITS);
			sw_s2 <= SUM_W'(p20_s1) + SUM_W'(p21_s1) + (SUM_W'(h22) <<< COORD_FRAC_BITS);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
	end

	// stage 3: magnitudes, result signs, degeneracy
	logic [SUM_W-1:0]          mx_s3, my_s3, mw_s3;
	logic                      negx_s3, negy_s3, deg_s3;
	logic signed [COORD_W-1:0] dx_s3, dy_s3;
	logic [SUM_W-1:0]          mw_c;
	assign mw_c = sw_s2[SUM_W-1] ? SUM_W'(-sw_s2) : SUM_W'(sw_s2);
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			mx_s3   <= sx_s2[SUM_W-1] ? SUM_W'(-sx_s2) : SUM_W'(sx_s2);
			my_s3   <= sy_s2[SUM_W-1] ? SUM_W'(-sy_s2) : SUM_W'(sy_s2);
			mw_s3   <= mw_c;
			negx_s3 <= sx_s2[SUM_W-1] ^ sw_s2[SUM_W-1];
			negy_s3 <= sy_s2[SUM_W-1] ^ sw_s2[SUM_W-1];
			deg_s3  <= (mw_c == '0) || (mw_c < SUM_W'(w_min_q));
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
		end
	end

	// divider pipeline; index 0 is stage 4, index j+1 is stage DS+j
	logic [NW-1:0]             rx_s [0:QUOT_W];
	logic [NW-1:0]             ry_s [0:QUOT_W];
	logic [QUOT_W-1:0]         qx_s [0:QUOT_W];
	logic [QUOT_W-1:0]         qy_s [0:QUOT_W];
	logic [SUM_W-1:0]          dv_s [0:QUOT_W];
	logic                      ovx_s [0:QUOT_W];
	logic                      ovy_s [0:QUOT_W];
	logic                      ngx_s [0:QUOT_W];
	logic                      ngy_s [0:QUOT_W];
	logic                      dg_s  [0:QUOT_W];
	logic signed [COORD_W-1:0] ddx_s [0:QUOT_W];
	logic signed [COORD_W-1:0] ddy_s [0:QUOT_W];

	// stage 4: scale numerators, flag quotients of 2^QUOT_W or more
	logic [CMP_W-1:0] dtop_c;
	assign dtop_c = CMP_W'(mw_s3) << QUOT_W;
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			rx_s[0]  <= NW'(mx_s3) << COORD_FRAC_BITS;
			ry_s[0]  <= NW'(my_s3) << COORD_FRAC_BITS;
			ovx_s[0] <= (CMP_W'(mx_s3) << COORD_FRAC_BITS) >= dtop_c;
			ovy_s[0] <= (CMP_W'(my_s3) << COORD_FRAC_BITS) >= dtop_c;
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
			dv_s[0]  <= mw_s3;
			ngx_s[0] <= negx_s3;
			ngy_s[0] <= negy_s3;
			dg_s[0]  <= deg_s3;
			ddx_s[0] <= dx_s3;
			ddy_s[0] <= dy_s3;
		end
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_div
		localparam int B = QUOT_W - 1 - j;
		logic [CMP_W-1:0] dsh, ax, ay, subx, suby;
		logic             gex, gey;
		always_comb begin
			dsh  = CMP_W'(dv_s[j]) << B;
			ax   = CMP_W'(rx_s[j]);
			ay   = CMP_W'(ry_s[j]);
			gex  = ax >= dsh;
			gey  = ay >= dsh;
			subx = ax - dsh;
			suby = ay - dsh;
		end
		always_ff @(posedge clk) begin
			if (adv[DS+j]) begin
				rx_s[j+1]  <= gex ? subx[NW-1:0] : rx_s[j];
				ry_s[j+1]  <= gey ? suby[NW-1:0] : ry_s[j];
				qx_s[j+1]  <= qx_s[j] | (QUOT_W'(gex) << B);
				qy_s[j+1]  <= qy_s[j] | (QUOT_W'(gey) << B);
				dv_s[j+1]  <= dv_s[j];
				ovx_s[j+1] <= ovx_s[j];
				ovy_s[j+1] <= ovy_s[j];
				ngx_s[j+1] <= ngx_s[j];
				ngy_s[j+1] <= ngy_s[j];
				dg_s[j+1]  <= dg_s[j];
				ddx_s[j+1] <= ddx_s[j];
				ddy_s[j+1] <= ddy_s[j];
			end
		end
	end

	// stage S_RND: round half away from zero, saturate, take differences
	logic [QUOT_W:0]           qrx, qry;
	logic signed [COORD_W-1:0] px_c, py_c;
	logic signed [COORD_W-1:0] px_r, py_r;
	logic signed [DIFF_W-1:0]  ex_r, ey_r;
	logic                      deg_r;
	always_comb begin
		qrx = (QUOT_W+1)'(qx_s[QUOT_W]) + (QUOT_W+1)'(
			{1'b0, rx_s[QUOT_W], 1'b0} >= (NW+2)'(dv_s[QUOT_W]));
		qry = (QUOT_W+1)'(qy_s[QUOT_W]) + (QUOT_W+1)'(
			{1'b0, ry_s[QUOT_W], 1'b0} >= (NW+2)'(dv_s[QUOT_W]));
		if (dg_s[QUOT_W])
			px_c = '0;
		else if (ngx_s[QUOT_W])
			px_c = (ovx_s[QUOT_W] || qrx > LIM_NEG) ? -$signed(LIM_NEG[COORD_W-1:0])
				: -$signed(qrx[COORD_W-1:0]);
		else
			px_c = (ovx_s[QUOT_W] || qrx > LIM_POS) ? $signed(LIM_POS[COORD_W-1:0])
				: $signed(qrx[COORD_W-1:0]);
		if (dg_s[QUOT_W])
			py_c = '0;
		else if (ngy_s[QUOT_W])
			py_c = (ovy_s[QUOT_W] || qry > LIM_NEG) ? -$signed(LIM_NEG[COORD_W-1:0])
				: -$signed(qry[COORD_W-1:0]);
		else
			py_c = (ovy_s[QUOT_W] || qry > LIM_POS) ? $signed(LIM_POS[COORD_W-1:0])
				: $signed(qry[COORD_W-1:0]);
	end
	always_ff @(posedge clk) begin
		if (adv[S_RND]) begin
			px_r  <= px_c;
			py_r  <= py_c;
			ex_r  <= DIFF_W'(px_c) - DIFF_W'(ddx_s[QUOT_W]);
			ey_r  <= DIFF_W'(py_c) - DIFF_W'(ddy_s[QUOT_W]);
			deg_r <= dg_s[QUOT_W];
		end
	end

	// stage S_SQ: squares
	logic [SQ_W-1:0]           sqx_q, sqy_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic                      deg_q;
	always_ff @(posedge clk) begin
		if (adv[S_SQ]) begin
			sqx_q <= SQ_W'(ex_r * ex_r);
			sqy_q <= SQ_W'(ey_r * ey_r);
			px_q  <= px_r;
			py_q  <= py_r;
			deg_q <= deg_r;
		end
	end

	// output register: sum and saturate
	logic [SQ_W:0] esum_c;
	assign esum_c = (SQ_W+1)'(sqx_q) + (SQ_W+1)'(sqy_q);
	always_ff @(posedge clk) begin
		if (adv[NS]) begin
			err_sq     <= (esum_c > (SQ_W+1)'(ERR_MAX)) ? ERR_MAX[ERR_W-1:0]
				: esum_c[ERR_W-1:0];
			proj_x     <= px_q;
			proj_y     <= py_q;
			degenerate <= deg_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_deg_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> proj_x == '0 && proj_y == '0)
		else $error("degenerate result not at origin");
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output stage");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[1])
		else $error("accepted request did not enter the first stage");
`endif
endmodule
`default_nettype wire
